@@ hdl/dss_pkg.sv @@
// Shared types, constants and helper functions of the diffusion-shock stencil pass.
// No dependencies; every other file of the block refers to it by scoped names.

package dss_pkg;

	// Frame limits and the widths that follow from them
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int WCNT_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int HCNT_BITS  = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT + 2);

	// Register file
	localparam int FW_BITS       = 12;
	localparam int FH_BITS       = 13;
	localparam int GAIN_BITS     = 7;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_IDX_BITS  = 3;

	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 480;
	localparam int RST_COHERENCE    = 84;
	localparam int RST_DIFFUSION    = 68;
	localparam int RST_SHOCK        = 34;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH    = 3'd0,
		REG_FRAME_HEIGHT   = 3'd1,
		REG_COHERENCE      = 3'd2,
		REG_DIFFUSION      = 3'd3,
		REG_SHOCK          = 3'd4
	} cfg_reg_t;

	// Arithmetic constants
	localparam int PIX_MAX   = 255;
	localparam int PCT_FULL  = 100;
	localparam int DIV_BLEND = 100;
	localparam int DIV_DIFF  = 118;
	localparam int DIV_SHOCK = 170;

	// Reciprocals for exact truncating division below 2^15
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_BITS  = 16;
	localparam int BLEND_BITS  = 16;
	localparam int MAG_BITS    = BLEND_BITS - 1;
	localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP_BLEND =
		RECIP_BITS'(((1 << RECIP_SHIFT) + DIV_BLEND - 1) / DIV_BLEND);
	localparam logic [RECIP_BITS-1:0] RECIP_DIFF =
		RECIP_BITS'(((1 << RECIP_SHIFT) + DIV_DIFF - 1) / DIV_DIFF);
	localparam logic [RECIP_BITS-1:0] RECIP_SHOCK =
		RECIP_BITS'(((1 << RECIP_SHIFT) + DIV_SHOCK - 1) / DIV_SHOCK);

	// Job queue between front and back
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QLVL_BITS = $clog2(QDEPTH + 1);

	typedef logic [7:0] pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	typedef struct packed {
		pix_t older;
		pix_t newer;
	} line_pair_t;

	typedef struct packed {
		column_t lc;
		column_t cc;
		column_t rc;
		logic    last;
	} job_t;

	typedef struct packed {
		logic [WCNT_BITS-1:0] width;
		logic [HCNT_BITS-1:0] height;
	} frame_cfg_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0] coherence;
		logic [GAIN_BITS-1:0] diffusion;
		logic [GAIN_BITS-1:0] shock;
	} gain_cfg_t;

	function automatic logic [WCNT_BITS-1:0] sat_width(input logic [FW_BITS-1:0] v);
		logic [WCNT_BITS-1:0] r;
		if (v == '0) begin
			r = WCNT_BITS'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WCNT_BITS'(MAX_WIDTH);
		end else begin
			r = WCNT_BITS'(v);
		end
		return r;
	endfunction

	function automatic logic [HCNT_BITS-1:0] sat_height(input logic [FH_BITS-1:0] v);
		logic [HCNT_BITS-1:0] r;
		if (v == '0) begin
			r = HCNT_BITS'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = HCNT_BITS'(MAX_HEIGHT);
		end else begin
			r = HCNT_BITS'(v);
		end
		return r;
	endfunction

	function automatic logic [GAIN_BITS-1:0] sat_gain(input logic [GAIN_BITS-1:0] v);
		return (int'(v) > PCT_FULL) ? GAIN_BITS'(PCT_FULL) : v;
	endfunction

endpackage

@@ hdl/dss_fifo.sv @@
// Short job queue between the window front and the arithmetic back.
// Depends on dss_pkg for the job type and queue depth.

module dss_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dss_pkg::job_t                 push_data,
	input  logic                          pop,
	output dss_pkg::job_t                 head,
	output logic                          not_empty,
	output logic [dss_pkg::QLVL_BITS-1:0] level
);

	dss_pkg::job_t                 slot_q [dss_pkg::QDEPTH];
	logic [dss_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [dss_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [dss_pkg::QLVL_BITS-1:0] count_q;

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dss_pkg::QPTR_BITS'(dss_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == dss_pkg::QPTR_BITS'(dss_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + dss_pkg::QLVL_BITS'(push) - dss_pkg::QLVL_BITS'(pop);
		end
	end

	// Credit check upstream must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < dss_pkg::QLVL_BITS'(dss_pkg::QDEPTH)) || pop)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("job queue popped while empty");

endmodule

@@ hdl/dss_front.sv @@
// Front of the stencil pass: accepts samples, tracks frame position, keeps the
// two-line store and column window, and pushes one 3x3 job per output pixel.
// Depends on dss_pkg.

module dss_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dss_pkg::frame_cfg_t           frame_cfg,
	input  logic                          restart,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dss_pkg::pix_t                 pixel_in,
	input  logic                          is_flush,
	input  logic [dss_pkg::QLVL_BITS-1:0] q_level,
	output logic                          job_push,
	output dss_pkg::job_t                 job
);

	typedef struct packed {
		logic [dss_pkg::COL_BITS-1:0] addr;
		dss_pkg::pix_t                sample;
		logic                         top_sel;
		logic                         bot_sample;
		logic                         produce;
		logic                         lc_edge;
		logic                         rc_edge;
		logic                         last;
	} item_t;

	logic                          accept;
	logic [dss_pkg::QLVL_BITS:0]   level;
	logic [dss_pkg::COL_BITS-1:0]  col_q;
	logic [dss_pkg::ROW_BITS-1:0]  row_q;
	logic                          at_end;
	logic                          col_wrap;
	item_t                         item;
	item_t                         item_s1;
	logic                          valid_s1;
	dss_pkg::line_pair_t           line_mem [dss_pkg::MAX_WIDTH];
	dss_pkg::line_pair_t           rd_q;
	dss_pkg::line_pair_t           fwd_data_q;
	logic                          fwd_q;
	dss_pkg::line_pair_t           lines;
	dss_pkg::line_pair_t           wr_data;
	dss_pkg::column_t              new_col;
	dss_pkg::column_t              col_a_q;
	dss_pkg::column_t              col_b_q;

	// Hold input while the queue could not take the item in flight plus this one
	assign level    = {1'b0, q_level} + (dss_pkg::QLVL_BITS + 1)'(valid_s1);
	assign in_stall = level >= (dss_pkg::QLVL_BITS + 1)'(dss_pkg::QDEPTH);
	assign accept   = in_valid && !in_stall;

	assign at_end   = row_q == (dss_pkg::ROW_BITS'(frame_cfg.height) + dss_pkg::ROW_BITS'(1));
	assign col_wrap = (dss_pkg::WCNT_BITS'(col_q) + dss_pkg::WCNT_BITS'(1)) == frame_cfg.width;

	always_comb begin
		item.addr       = col_q;
		item.sample     = is_flush ? '0 : pixel_in;
		item.top_sel    = row_q >= dss_pkg::ROW_BITS'(2);
		item.bot_sample = row_q < dss_pkg::ROW_BITS'(frame_cfg.height);
		item.produce    = (row_q >= dss_pkg::ROW_BITS'(2)) ||
			((row_q == dss_pkg::ROW_BITS'(1)) && (col_q != '0));
		item.lc_edge    = (col_q == dss_pkg::COL_BITS'(1)) ||
			((col_q == '0) && (frame_cfg.width == dss_pkg::WCNT_BITS'(1)));
		item.rc_edge    = col_q == '0;
		item.last       = (col_q == '0) && at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (at_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Two-line store: read at accept, write back in the following cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[item_s1.addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q       <= line_mem[col_q];
			fwd_q      <= valid_s1 && (item_s1.addr == col_q);
			fwd_data_q <= wr_data;
		end
	end

	// Forward the write that lands on the same edge as the read (one-pixel lines)
	assign lines = fwd_q ? fwd_data_q : rd_q;

	always_comb begin
		new_col.mid   = lines.newer;
		new_col.top   = item_s1.top_sel ? lines.older : lines.newer;
		new_col.bot   = item_s1.bot_sample ? item_s1.sample : lines.newer;
		wr_data.older = new_col.mid;
		wr_data.newer = new_col.bot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_a_q <= '0;
			col_b_q <= '0;
		end else if (valid_s1) begin
			col_a_q <= col_b_q;
			col_b_q <= new_col;
		end
	end

	// Replicate the center column at the left and right frame edges
	always_comb begin
		job.lc   = item_s1.lc_edge ? col_b_q : col_a_q;
		job.cc   = col_b_q;
		job.rc   = item_s1.rc_edge ? col_b_q : new_col;
		job.last = item_s1.last;
	end

	assign job_push = valid_s1 && item_s1.produce;

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last) |=> (col_q == '0) && (row_q == '0))
		else $error("position did not restart after the final pixel of the frame");

	a_position_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(dss_pkg::WCNT_BITS'(col_q) < frame_cfg.width) &&
		(row_q <= (dss_pkg::ROW_BITS'(frame_cfg.height) + dss_pkg::ROW_BITS'(1))))
		else $error("frame position outside the configured frame");

endmodule

@@ hdl/dss_back.sv @@
// Back of the stencil pass: five arithmetic stages and the output register that
// turn one 3x3 job into a filtered pixel. Depends on dss_pkg.

module dss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dss_pkg::gain_cfg_t  gain,
	input  logic                job_valid,
	input  dss_pkg::job_t       job,
	output logic                job_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output dss_pkg::pix_t       pixel_out,
	output logic                frame_last
);

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;

	// stage 1 inputs
	dss_pkg::pix_t c, l, r, u, d, ul, ur, dl, dr;
	dss_pkg::pix_t ax, ay, pa, pb, tang_avg, iso_avg, grad;
	logic          gx_neg, gy_neg;
	logic [9:0]    sum4, sum4_rnd, c4;
	logic [8:0]    gsum, pair;

	dss_pkg::pix_t      c_s1, c_s2, c_s3, c_s4, c_s5;
	logic               last_s1, last_s2, last_s3, last_s4, last_s5;
	logic               lap_pos_s1, lap_pos_s2, lap_pos_s3;
	logic               lap_neg_s1, lap_neg_s2, lap_neg_s3;
	logic signed [8:0]  tang_s1, iso_s1;
	dss_pkg::pix_t      grad_s1;

	// stage 2
	logic [dss_pkg::GAIN_BITS-1:0]    iso_wt;
	logic signed [16:0]               blend_full;
	logic [14:0]                      gs;
	logic signed [dss_pkg::BLEND_BITS-1:0] blend_s2;
	logic [14:0]                      gs_s2;

	// stage 3
	logic                             blend_neg;
	logic [dss_pkg::MAG_BITS-1:0]     blend_mag;
	logic [dss_pkg::PROD_BITS-1:0]    blend_prod, shock_prod;
	dss_pkg::pix_t                    blend_q, shock_q;
	logic signed [8:0]                diff1_s3;
	dss_pkg::pix_t                    shock_s3;

	// stage 4
	logic signed [16:0]               scaled_full;
	logic signed [dss_pkg::BLEND_BITS-1:0] scaled_s4;
	logic signed [8:0]                shock_s4, shock_s5;

	// stage 5
	logic                             scaled_neg;
	logic [dss_pkg::MAG_BITS-1:0]     scaled_mag;
	logic [dss_pkg::PROD_BITS-1:0]    diff_prod;
	dss_pkg::pix_t                    diff_q;
	logic signed [8:0]                diff_s5;

	// output
	logic signed [10:0]               sum_v;
	dss_pkg::pix_t                    sat_v;
	dss_pkg::pix_t                    pixel_q;
	logic                             last_q;

	// Whole pipeline moves unless a finished pixel is waiting on the output
	assign adv       = !out_valid_q || !out_stall;
	assign job_pop   = job_valid && adv;
	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign frame_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= job_pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	// Stage 1: gradient, direction pick, tangential and isotropic averages
	always_comb begin
		c  = job.cc.mid;
		u  = job.cc.top;
		d  = job.cc.bot;
		l  = job.lc.mid;
		ul = job.lc.top;
		dl = job.lc.bot;
		r  = job.rc.mid;
		ur = job.rc.top;
		dr = job.rc.bot;

		gx_neg = r < l;
		gy_neg = d < u;
		ax     = gx_neg ? (l - r) : (r - l);
		ay     = gy_neg ? (u - d) : (d - u);

		sum4     = 10'(l) + 10'(r) + 10'(u) + 10'(d);
		sum4_rnd = sum4 + 10'd2;
		iso_avg  = sum4_rnd[9:2];
		c4       = {c, 2'b00};

		gsum = 9'(ax) + 9'(ay);
		grad = (gsum > 9'(dss_pkg::PIX_MAX)) ? 8'(dss_pkg::PIX_MAX) : gsum[7:0];

		if ({1'b0, ax} > {ay, 1'b0}) begin
			pa = u;
			pb = d;
		end else if ({1'b0, ay} > {ax, 1'b0}) begin
			pa = l;
			pb = r;
		end else if (gx_neg == gy_neg) begin
			pa = ur;
			pb = dl;
		end else begin
			pa = ul;
			pb = dr;
		end
		pair     = 9'(pa) + 9'(pb) + 9'd1;
		tang_avg = pair[8:1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1       <= c;
			last_s1    <= job.last;
			tang_s1    <= $signed({1'b0, tang_avg}) - $signed({1'b0, c});
			iso_s1     <= $signed({1'b0, iso_avg}) - $signed({1'b0, c});
			grad_s1    <= grad;
			lap_pos_s1 <= sum4 > c4;
			lap_neg_s1 <= sum4 < c4;
		end
	end

	// Stage 2: coherence blend and shock magnitude products
	assign iso_wt     = dss_pkg::GAIN_BITS'(dss_pkg::PCT_FULL) - gain.coherence;
	assign blend_full = tang_s1 * $signed({1'b0, gain.coherence}) +
		iso_s1 * $signed({1'b0, iso_wt});
	assign gs         = grad_s1 * gain.shock;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2       <= c_s1;
			last_s2    <= last_s1;
			lap_pos_s2 <= lap_pos_s1;
			lap_neg_s2 <= lap_neg_s1;
			blend_s2   <= blend_full[dss_pkg::BLEND_BITS-1:0];
			gs_s2      <= gs;
		end
	end

	// Stage 3: divide by 100 and 170 (exact below 2^15), truncating toward zero
	always_comb begin
		blend_neg  = blend_s2[dss_pkg::BLEND_BITS-1];
		blend_mag  = blend_neg ? dss_pkg::MAG_BITS'(-blend_s2) :
			blend_s2[dss_pkg::MAG_BITS-1:0];
		blend_prod = blend_mag * dss_pkg::RECIP_BLEND;
		blend_q    = blend_prod[dss_pkg::RECIP_SHIFT +: 8];
		shock_prod = gs_s2 * dss_pkg::RECIP_SHOCK;
		shock_q    = shock_prod[dss_pkg::RECIP_SHIFT +: 8];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3       <= c_s2;
			last_s3    <= last_s2;
			lap_pos_s3 <= lap_pos_s2;
			lap_neg_s3 <= lap_neg_s2;
			diff1_s3   <= blend_neg ? -$signed({1'b0, blend_q}) : $signed({1'b0, blend_q});
			shock_s3   <= shock_q;
		end
	end

	// Stage 4: diffusion scale; give the shock the sign opposite to the Laplacian
	assign scaled_full = diff1_s3 * $signed({1'b0, gain.diffusion});

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4      <= c_s3;
			last_s4   <= last_s3;
			scaled_s4 <= scaled_full[dss_pkg::BLEND_BITS-1:0];
			if (lap_pos_s3) begin
				shock_s4 <= -$signed({1'b0, shock_s3});
			end else if (lap_neg_s3) begin
				shock_s4 <= $signed({1'b0, shock_s3});
			end else begin
				shock_s4 <= '0;
			end
		end
	end

	// Stage 5: divide by 118, truncating toward zero
	always_comb begin
		scaled_neg = scaled_s4[dss_pkg::BLEND_BITS-1];
		scaled_mag = scaled_neg ? dss_pkg::MAG_BITS'(-scaled_s4) :
			scaled_s4[dss_pkg::MAG_BITS-1:0];
		diff_prod  = scaled_mag * dss_pkg::RECIP_DIFF;
		diff_q     = diff_prod[dss_pkg::RECIP_SHIFT +: 8];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5     <= c_s4;
			last_s5  <= last_s4;
			shock_s5 <= shock_s4;
			diff_s5  <= scaled_neg ? -$signed({1'b0, diff_q}) : $signed({1'b0, diff_q});
		end
	end

	// Output: sum and clamp to the pixel range
	always_comb begin
		sum_v = $signed({3'b000, c_s5}) + $signed({{2{diff_s5[8]}}, diff_s5}) +
			$signed({{2{shock_s5[8]}}, shock_s5});
		if (sum_v[10]) begin
			sat_v = '0;
		end else if (sum_v[9:8] != 2'b00) begin
			sat_v = 8'(dss_pkg::PIX_MAX);
		end else begin
			sat_v = sum_v[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q <= sat_v;
			last_q  <= last_s5;
		end
	end

endmodule

@@ hdl/diffusion_shock_stencil_pass_top.sv @@
// Top level of the diffusion-shock stencil pass: register file and the
// front / job queue / back chain. Depends on dss_pkg, dss_front, dss_fifo, dss_back.

// One pass of a 3x3 diffusion-shock filter over 8-bit luma in raster order,
// with replicated frame edges. After the width*height pixels of a frame, send
// width+1 flush items (is_flush high); a pixel sent during that drain counts as
// a flush, and a flush sent among the pixels counts as a zero sample. The
// result for pixel k is produced by input item k+width+1, so pixels come out in
// raster order and frame_last marks the last one; the next item starts a new
// frame. The block sustains one item per clock: the front reads the two-line
// store at accept and writes it back the next cycle, so each line position
// costs one read and one write, and a four-entry job queue separates the front
// from the six-stage arithmetic back. While out_stall holds a finished pixel
// the whole back stops; the queue takes up the slack, and once it fills the
// input stalls. An item passes the front's item register, the queue and the
// back's stages on its way to out_valid. in_stall rises once the queued jobs
// plus the job being built in the front reach four, so the queue never
// overflows. Writing frame_width or frame_height restarts the frame
// position; all writes are meant for an idle block, and cfg_ready is always
// high. Width saturates to 1..2048, height to 1..4096, strengths to 0..100. The
// line store needs no clearing after reset: no stale entry reaches a result.

module diffusion_shock_stencil_pass_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [dss_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// sample input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        pixel_in,
	input  logic                              is_flush,
	// filtered output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        pixel_out,
	output logic                              frame_last
);

	logic                                cfg_we;
	logic                                restart;
	logic [dss_pkg::WCNT_BITS-1:0]       width_q;
	logic [dss_pkg::HCNT_BITS-1:0]       height_q;
	logic [dss_pkg::GAIN_BITS-1:0]       coh_q;
	logic [dss_pkg::GAIN_BITS-1:0]       dif_q;
	logic [dss_pkg::GAIN_BITS-1:0]       shk_q;
	dss_pkg::frame_cfg_t                 frame_cfg;
	dss_pkg::gain_cfg_t                  gain_cfg;

	logic                                job_push;
	dss_pkg::job_t                       job_in;
	logic                                job_pop;
	dss_pkg::job_t                       job_head;
	logic                                job_ready;
	logic [dss_pkg::QLVL_BITS-1:0]       q_level;

	// Registers are always writable, so every transfer is taken when offered
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Restart the frame position on any write to the frame size
	assign restart = cfg_we &&
		(cfg_index inside {dss_pkg::REG_FRAME_WIDTH, dss_pkg::REG_FRAME_HEIGHT});

	// Store values already saturated to their legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dss_pkg::WCNT_BITS'(dss_pkg::RST_FRAME_WIDTH);
			height_q <= dss_pkg::HCNT_BITS'(dss_pkg::RST_FRAME_HEIGHT);
			coh_q    <= dss_pkg::GAIN_BITS'(dss_pkg::RST_COHERENCE);
			dif_q    <= dss_pkg::GAIN_BITS'(dss_pkg::RST_DIFFUSION);
			shk_q    <= dss_pkg::GAIN_BITS'(dss_pkg::RST_SHOCK);
		end else if (cfg_we) begin
			case (cfg_index)
				dss_pkg::REG_FRAME_WIDTH: begin
					width_q <= dss_pkg::sat_width(cfg_data[dss_pkg::FW_BITS-1:0]);
				end
				dss_pkg::REG_FRAME_HEIGHT: begin
					height_q <= dss_pkg::sat_height(cfg_data[dss_pkg::FH_BITS-1:0]);
				end
				dss_pkg::REG_COHERENCE: begin
					coh_q <= dss_pkg::sat_gain(cfg_data[dss_pkg::GAIN_BITS-1:0]);
				end
				dss_pkg::REG_DIFFUSION: begin
					dif_q <= dss_pkg::sat_gain(cfg_data[dss_pkg::GAIN_BITS-1:0]);
				end
				dss_pkg::REG_SHOCK: begin
					shk_q <= dss_pkg::sat_gain(cfg_data[dss_pkg::GAIN_BITS-1:0]);
				end
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign frame_cfg.width     = width_q;
	assign frame_cfg.height    = height_q;
	assign gain_cfg.coherence  = coh_q;
	assign gain_cfg.diffusion  = dif_q;
	assign gain_cfg.shock      = shk_q;

	// Front: position tracking, line store, window, job build
	dss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_cfg (frame_cfg),
		.restart   (restart),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.is_flush  (is_flush),
		.q_level   (q_level),
		.job_push  (job_push),
		.job       (job_in)
	);

	// Queue: lets the front keep taking samples while the output is held
	dss_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (job_pop),
		.head      (job_head),
		.not_empty (job_ready),
		.level     (q_level)
	);

	// Back: filter arithmetic and output register
	dss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain       (gain_cfg),
		.job_valid  (job_ready),
		.job        (job_head),
		.job_pop    (job_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

endmodule
